### design/uvs_pkg.sv
// Shared types, constants and helper functions for the UV-sphere vertex attribute block.
package uvs_pkg;

	// Fixed formats
	localparam int MAX_DIVISIONS = 1024;
	localparam int FRAC_BITS     = 16;
	localparam int CNT_W         = 11;
	localparam int RAD_W         = 16;
	localparam int MODE_W        = 3;
	localparam int IDX_W         = 2;
	localparam int COMP_W        = 32;
	localparam int TEX_W         = FRAC_BITS + 1;

	// Reset values of the registers
	localparam logic [CNT_W-1:0] RING_COUNT_RST = CNT_W'(16);
	localparam logic [CNT_W-1:0] SEG_COUNT_RST  = CNT_W'(32);
	localparam logic [RAD_W-1:0] RADIUS_RST     = RAD_W'(256);

	// Long division chain: one integer bit plus DIV_STEPS fraction bits
	localparam int DIV_STEPS = 32;
	localparam int QW        = DIV_STEPS + 1;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int SNAP_TEX  = FRAC_BITS;
	localparam int SNAP_ANG  = DIV_STEPS - 1;

	// Trig arithmetic, Q30
	localparam int XW = 31;
	localparam int TW = 31;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [TW-1:0] QONE      = TW'(1) << 30;
	localparam logic [47:0] TAN_EPS_Q38 = 48'd274878;

	// Horner cells: cos uses all six, sin skips the first
	localparam int HORNER_CELLS = 6;
	localparam int DIVC_W       = 8;
	localparam logic [DIVC_W-1:0] COS_DIV [HORNER_CELLS] = '{
		8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam logic [DIVC_W-1:0] SIN_DIV [HORNER_CELLS] = '{
		8'd1, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [HORNER_CELLS-1:0] SIN_ON = 6'b111110;
	localparam logic [31:0] COS_RECIP [HORNER_CELLS] = '{
		32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90),
		32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
		32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};
	localparam logic [31:0] SIN_RECIP [HORNER_CELLS] = '{
		32'd0, 32'((64'd1 << 32) / 110),
		32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
		32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};

	// Attribute kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_POS2D   = 3'd0,
		MODE_POS3D   = 3'd1,
		MODE_TEX     = 3'd2,
		MODE_NORMAL  = 3'd3,
		MODE_TANGENT = 3'd4,
		MODE_BITAN   = 3'd5
	} uvs_mode_t;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_RING_COUNT = 2'd0,
		REG_SEG_COUNT  = 2'd1,
		REG_RADIUS     = 2'd2
	} uvs_reg_t;

	// Beat in the long division chain
	typedef struct packed {
		logic             vld;
		uvs_mode_t        mode;
		logic [QW-1:0]    rq;
		logic [QW-1:0]    sq;
		logic [CNT_W-1:0] rr;
		logic [CNT_W-1:0] sr;
		logic [CNT_W-1:0] rr_tex;
		logic [CNT_W-1:0] sr_tex;
		logic [CNT_W-1:0] rr_ang;
		logic [STEP_W-1:0] step;
	} uvs_div_t;

	// Beat in the Horner chain; lanes: sin theta, cos theta, sin phi, cos phi
	typedef struct packed {
		logic                 vld;
		uvs_mode_t            mode;
		logic [TEX_W-1:0]     tex_u;
		logic [TEX_W-1:0]     tex_v;
		logic [1:0][1:0]      quad;
		logic [1:0][XW-1:0]   x;
		logic [1:0][31:0]     x2;
		logic [3:0][TW-1:0]   t;
	} uvs_trig_t;

	// Clamp a division count into 1..MAX_DIVISIONS
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		if (v == '0) return CNT_W'(1);
		if (v > CNT_W'(MAX_DIVISIONS)) return CNT_W'(MAX_DIVISIONS);
		return v;
	endfunction

	// Arithmetic shift right by k, round to nearest, ties away from zero
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
			input int unsigned k);
		logic [63:0] mag;
		logic [63:0] half;
		half = 64'd1 << (k - 1);
		mag  = v[63] ? 64'(-v) : 64'(v);
		mag  = (mag + half) >> k;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	// Saturate to signed 32 bits
	function automatic logic [COMP_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage

### design/uvs_if.sv
// Valid/ready channel interfaces for vertex requests and attribute results.
interface uvs_in_if import uvs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  ring_index;
	logic [CNT_W-1:0]  segment_index;
	logic [MODE_W-1:0] mode;

	modport source (output valid, ring_index, segment_index, mode, input ready);
	modport sink (input valid, ring_index, segment_index, mode, output ready);
endinterface

interface uvs_out_if import uvs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [COMP_W-1:0] comp_x;
	logic [COMP_W-1:0] comp_y;
	logic [COMP_W-1:0] comp_z;
	logic [1:0]        comp_count;

	modport source (output valid, comp_x, comp_y, comp_z, comp_count, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, comp_count, output ready);
endinterface

### design/uvs_div_cell.sv
// One restoring division step for the ring and segment angle fractions.
module uvs_div_cell import uvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CNT_W-1:0] ring_div,
	input  logic [CNT_W-1:0] seg_div,
	input  uvs_div_t         d_in,
	output uvs_div_t         d_out
);

	logic [CNT_W:0]   r2, s2;
	logic             rge, sge;
	logic [CNT_W-1:0] rrem, srem;
	uvs_div_t         nxt;

	// Shift remainder, subtract divisor when it fits, shift in quotient bit
	always_comb begin
		r2   = {d_in.rr, 1'b0};
		s2   = {d_in.sr, 1'b0};
		rge  = r2 >= {1'b0, ring_div};
		sge  = s2 >= {1'b0, seg_div};
		rrem = rge ? CNT_W'(r2 - {1'b0, ring_div}) : CNT_W'(r2);
		srem = sge ? CNT_W'(s2 - {1'b0, seg_div}) : CNT_W'(s2);
		nxt      = d_in;
		nxt.rq   = {d_in.rq[QW-2:0], rge};
		nxt.sq   = {d_in.sq[QW-2:0], sge};
		nxt.rr   = rrem;
		nxt.sr   = srem;
		nxt.step = d_in.step + STEP_W'(1);
		// keep remainders needed for the coarser roundings
		if (nxt.step == STEP_W'(SNAP_TEX)) begin
			nxt.rr_tex = rrem;
			nxt.sr_tex = srem;
		end
		if (nxt.step == STEP_W'(SNAP_ANG)) begin
			nxt.rr_ang = rrem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out <= nxt;
		end
	end

endmodule

### design/uvs_horner_cell.sv
// One Horner step of the sin/cos series on four lanes, three stages deep.
module uvs_horner_cell import uvs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [DIVC_W-1:0] cos_div,
	input  logic [31:0]       cos_recip,
	input  logic [DIVC_W-1:0] sin_div,
	input  logic [31:0]       sin_recip,
	input  logic              sin_on,
	input  uvs_trig_t         d_in,
	output uvs_trig_t         d_out
);

	uvs_trig_t        item_s1, item_s2;
	logic [3:0][31:0] v_s1, v_s2, q_s2;
	logic [3:0][31:0] v_d, q_d;
	uvs_trig_t        nxt;

	// Stage 1: x2 * t in Q30
	always_comb begin
		logic [63:0] prod;
		for (int j = 0; j < 4; j++) begin
			prod   = 64'(d_in.x2[j/2]) * 64'(d_in.t[j]);
			v_d[j] = prod[61:30];
		end
	end

	// Stage 2: quotient estimate by reciprocal, at most one short
	always_comb begin
		logic [63:0] prod;
		for (int j = 0; j < 4; j++) begin
			prod   = 64'(v_s1[j]) * 64'(j % 2 == 1 ? cos_recip : sin_recip);
			q_d[j] = prod[63:32];
		end
	end

	// Stage 3: correct the quotient and form 1 - p, clamped at zero
	always_comb begin
		logic [39:0]       rem;
		logic [DIVC_W-1:0] dv;
		logic [31:0]       p;
		nxt = item_s2;
		for (int j = 0; j < 4; j++) begin
			dv  = (j % 2 == 1) ? cos_div : sin_div;
			rem = 40'(v_s2[j]) - 40'(q_s2[j]) * 40'(dv);
			p   = q_s2[j] + ((rem >= 40'(dv)) ? 32'd1 : 32'd0);
			if (j % 2 == 1 || sin_on) begin
				nxt.t[j] = (p >= 32'(QONE)) ? '0 : TW'(32'(QONE) - p);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
			d_out   <= '0;
		end else if (en) begin
			item_s1 <= d_in;
			item_s2 <= item_s1;
			d_out   <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v_d;
			v_s2 <= v_s1;
			q_s2 <= q_d;
		end
	end

endmodule

### design/uv_sphere_vertex_attributes_top.sv
// Top level of the UV-sphere vertex attribute generator.
//
// Usage: vtx_in carries one beat per request (ring_index, segment_index, mode);
// vtx_out returns one beat per request in order with comp_x/y/z in signed
// Q16.16 and comp_count (2 or 3). Configuration (ring count, segment count,
// radius in Q8.8) is written through cfg_we/cfg_index/cfg_wdata while no
// request is in flight; counts are clamped to 1..1024 and a zero radius to 1.
// From input acceptance to output valid a beat passes one entry stage,
// 32 long-division cells for the angle fractions, three angle/square stages,
// six Horner cells of three stages each for sin and cos, four stages for the
// normal, tangent and cross products, and the output register.
// Throughput is one beat per cycle. The whole pipeline advances together;
// vtx_in.ready is high when the output register is empty or being taken, so
// when the receiver stalls with a result waiting the pipe holds and input
// stops until the result is taken.
// Reset is asynchronous: all valid bits clear and the registers return to
// ring count 16, segment count 32, radius 1.0.
module uv_sphere_vertex_attributes_top import uvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [RAD_W-1:0] cfg_wdata,
	uvs_in_if.sink           vtx_in,
	uvs_out_if.source        vtx_out
);

	typedef struct packed {
		logic             vld;
		uvs_mode_t        mode;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
		logic [1:0][31:0] ang;
	} uvs_rnd_t;

	typedef struct packed {
		logic               vld;
		uvs_mode_t          mode;
		logic [TEX_W-1:0]   tex_u;
		logic [TEX_W-1:0]   tex_v;
		logic [1:0][1:0]    quad;
		logic [1:0][XW-1:0] x;
	} uvs_ang_t;

	typedef struct packed {
		logic               vld;
		uvs_mode_t          mode;
		logic [TEX_W-1:0]   tex_u;
		logic [TEX_W-1:0]   tex_v;
		logic [1:0][1:0]    quad;
		logic [1:0][31:0]   s0;
		logic [1:0][TW-1:0] c0;
	} uvs_f5_t;

	typedef struct packed {
		logic               vld;
		uvs_mode_t          mode;
		logic [TEX_W-1:0]   tex_u;
		logic [TEX_W-1:0]   tex_v;
		logic signed [31:0] ct;
		logic signed [31:0] sp;
		logic signed [31:0] cp;
		logic signed [63:0] pt;
		logic signed [63:0] pp;
		logic [47:0]        rt;
	} uvs_f6_t;

	typedef struct packed {
		logic               vld;
		uvs_mode_t          mode;
		logic [TEX_W-1:0]   tex_u;
		logic [TEX_W-1:0]   tex_v;
		logic signed [31:0] n0;
		logic signed [31:0] n1;
		logic signed [31:0] n2;
		logic signed [31:0] tg0;
		logic signed [31:0] tg2;
	} uvs_f7_t;

	typedef struct packed {
		logic               vld;
		uvs_mode_t          mode;
		logic [TEX_W-1:0]   tex_u;
		logic [TEX_W-1:0]   tex_v;
		logic signed [31:0] n0;
		logic signed [31:0] n1;
		logic signed [31:0] n2;
		logic signed [31:0] tg0;
		logic signed [31:0] tg2;
		logic signed [63:0] ba;
		logic signed [63:0] bb;
		logic signed [63:0] bc;
		logic signed [63:0] bd;
		logic signed [63:0] pos0;
		logic signed [63:0] pos1;
		logic signed [63:0] pos2;
	} uvs_f8_t;

	typedef struct packed {
		logic              vld;
		logic [COMP_W-1:0] x;
		logic [COMP_W-1:0] y;
		logic [COMP_W-1:0] z;
		logic [1:0]        cnt;
	} uvs_res_t;

	logic [CNT_W-1:0] nr_q, ns_q;
	logic [RAD_W-1:0] rad_q;
	logic             adv;

	uvs_div_t  div_pipe [DIV_STEPS+1];
	uvs_trig_t hrn_pipe [HORNER_CELLS+1];
	uvs_div_t  ent_d;
	uvs_rnd_t  rnd_s2, rnd_d;
	uvs_ang_t  ang_s3, ang_d;
	uvs_trig_t trg_d;
	uvs_f5_t   f5_s5, f5_d;
	uvs_f6_t   f6_s6, f6_d;
	uvs_f7_t   f7_s7, f7_d;
	uvs_f8_t   f8_s8, f8_d;
	uvs_res_t  res_s9, res_d;

	// Configuration registers, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nr_q  <= RING_COUNT_RST;
			ns_q  <= SEG_COUNT_RST;
			rad_q <= RADIUS_RST;
		end else if (cfg_we) begin
			case (uvs_reg_t'(cfg_index))
				REG_RING_COUNT: nr_q <= clamp_count(cfg_wdata[CNT_W-1:0]);
				REG_SEG_COUNT:  ns_q <= clamp_count(cfg_wdata[CNT_W-1:0]);
				REG_RADIUS:     rad_q <= (cfg_wdata == '0) ? RAD_W'(1) : cfg_wdata;
				default: ;
			endcase
		end
	end

	// Whole pipe moves when the output register can take a beat
	assign adv          = !res_s9.vld || vtx_out.ready;
	assign vtx_in.ready = adv;

	// Entry: clamp indices, integer quotient bit
	always_comb begin
		logic [CNT_W-1:0] ri, si;
		ri = (vtx_in.ring_index > nr_q) ? nr_q : vtx_in.ring_index;
		si = (vtx_in.segment_index > ns_q) ? ns_q : vtx_in.segment_index;
		ent_d      = '0;
		ent_d.vld  = vtx_in.valid;
		ent_d.mode = uvs_mode_t'(vtx_in.mode);
		ent_d.rq   = QW'(ri == nr_q);
		ent_d.sq   = QW'(si == ns_q);
		ent_d.rr   = (ri == nr_q) ? '0 : ri;
		ent_d.sr   = (si == ns_q) ? '0 : si;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_pipe[0] <= '0;
		end else if (adv) begin
			div_pipe[0] <= ent_d;
		end
	end

	// Long division chain
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		uvs_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ring_div (nr_q),
			.seg_div  (ns_q),
			.d_in     (div_pipe[i]),
			.d_out    (div_pipe[i+1])
		);
	end

	// Rounded angles and texcoords
	always_comb begin
		uvs_div_t         dv;
		logic [CNT_W-1:0] hr, hs;
		dv = div_pipe[DIV_STEPS];
		hr = nr_q >> 1;
		hs = ns_q >> 1;
		rnd_d.vld    = dv.vld;
		rnd_d.mode   = dv.mode;
		rnd_d.ang[0] = dv.rq[QW-1:1] +
			32'(({1'b0, dv.rr_ang} + {1'b0, hr}) >= {1'b0, nr_q});
		rnd_d.ang[1] = dv.sq[QW-2:0] +
			32'(({1'b0, dv.sr} + {1'b0, hs}) >= {1'b0, ns_q});
		rnd_d.tex_u  = TEX_W'(dv.sq >> (DIV_STEPS - FRAC_BITS)) +
			TEX_W'(({1'b0, dv.sr_tex} + {1'b0, hs}) >= {1'b0, ns_q});
		rnd_d.tex_v  = TEX_W'(dv.rq >> (DIV_STEPS - FRAC_BITS)) +
			TEX_W'(({1'b0, dv.rr_tex} + {1'b0, hr}) >= {1'b0, nr_q});
	end

	// Quadrant split and scaling to radians
	always_comb begin
		logic [60:0] prod;
		ang_d.vld   = rnd_s2.vld;
		ang_d.mode  = rnd_s2.mode;
		ang_d.tex_u = rnd_s2.tex_u;
		ang_d.tex_v = rnd_s2.tex_v;
		for (int a = 0; a < 2; a++) begin
			ang_d.quad[a] = rnd_s2.ang[a][31:30];
			prod          = 61'(rnd_s2.ang[a][29:0]) * 61'(HALF_PI_Q30) + (61'(1) << 29);
			ang_d.x[a]    = prod[60:30];
		end
	end

	// Square of the reduced angle, series start at one
	always_comb begin
		logic [61:0] prod;
		trg_d       = '0;
		trg_d.vld   = ang_s3.vld;
		trg_d.mode  = ang_s3.mode;
		trg_d.tex_u = ang_s3.tex_u;
		trg_d.tex_v = ang_s3.tex_v;
		trg_d.quad  = ang_s3.quad;
		trg_d.x     = ang_s3.x;
		for (int a = 0; a < 2; a++) begin
			prod        = 62'(ang_s3.x[a]) * 62'(ang_s3.x[a]) + (62'(1) << 29);
			trg_d.x2[a] = prod[61:30];
		end
		for (int j = 0; j < 4; j++) begin
			trg_d.t[j] = QONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_s2      <= '0;
			ang_s3      <= '0;
			hrn_pipe[0] <= '0;
		end else if (adv) begin
			rnd_s2      <= rnd_d;
			ang_s3      <= ang_d;
			hrn_pipe[0] <= trg_d;
		end
	end

	// Horner chain for sin and cos of both angles
	for (genvar k = 0; k < HORNER_CELLS; k++) begin : g_hrn
		uvs_horner_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.cos_div   (COS_DIV[k]),
			.cos_recip (COS_RECIP[k]),
			.sin_div   (SIN_DIV[k]),
			.sin_recip (SIN_RECIP[k]),
			.sin_on    (SIN_ON[k]),
			.d_in      (hrn_pipe[k]),
			.d_out     (hrn_pipe[k+1])
		);
	end

	// sin = x * series
	always_comb begin
		uvs_trig_t   h;
		logic [61:0] prod;
		h = hrn_pipe[HORNER_CELLS];
		f5_d.vld   = h.vld;
		f5_d.mode  = h.mode;
		f5_d.tex_u = h.tex_u;
		f5_d.tex_v = h.tex_v;
		f5_d.quad  = h.quad;
		for (int a = 0; a < 2; a++) begin
			prod        = 62'(h.x[a]) * 62'(h.t[2*a]);
			f5_d.s0[a]  = prod[61:30];
			f5_d.c0[a]  = h.t[2*a+1];
		end
	end

	// Quadrant fold, normal products, pole magnitude
	always_comb begin
		logic signed [31:0] sn [2];
		logic signed [31:0] cs [2];
		logic signed [31:0] s0, c0;
		logic [31:0]        ast;
		for (int a = 0; a < 2; a++) begin
			s0 = $signed(f5_s5.s0[a]);
			c0 = $signed(32'(f5_s5.c0[a]));
			case (f5_s5.quad[a])
				2'd0: begin sn[a] = s0;  cs[a] = c0;  end
				2'd1: begin sn[a] = c0;  cs[a] = -s0; end
				2'd2: begin sn[a] = -s0; cs[a] = -c0; end
				default: begin sn[a] = -c0; cs[a] = s0; end
			endcase
		end
		ast = sn[0][31] ? 32'(-sn[0]) : 32'(sn[0]);
		f6_d.vld   = f5_s5.vld;
		f6_d.mode  = f5_s5.mode;
		f6_d.tex_u = f5_s5.tex_u;
		f6_d.tex_v = f5_s5.tex_v;
		f6_d.ct    = cs[0];
		f6_d.sp    = sn[1];
		f6_d.cp    = cs[1];
		f6_d.pt    = 64'(sn[0]) * 64'(cs[1]);
		f6_d.pp    = 64'(sn[0]) * 64'(sn[1]);
		f6_d.rt    = 48'(rad_q) * 48'(ast);
	end

	// Normal rounding and tangent with pole fallback
	always_comb begin
		logic pole;
		pole = f6_s6.rt < TAN_EPS_Q38;
		f7_d.vld   = f6_s6.vld;
		f7_d.mode  = f6_s6.mode;
		f7_d.tex_u = f6_s6.tex_u;
		f7_d.tex_v = f6_s6.tex_v;
		f7_d.n0    = 32'(round_shift(f6_s6.pt, 30));
		f7_d.n1    = f6_s6.ct;
		f7_d.n2    = 32'(round_shift(f6_s6.pp, 30));
		if (pole) begin
			f7_d.tg0 = '0;
			f7_d.tg2 = f6_s6.ct[31] ? -$signed(32'(QONE)) : $signed(32'(QONE));
		end else begin
			f7_d.tg0 = -f6_s6.sp;
			f7_d.tg2 = f6_s6.cp;
		end
	end

	// Cross-product terms and scaled position
	always_comb begin
		logic signed [RAD_W:0] rs;
		rs = $signed({1'b0, rad_q});
		f8_d.vld   = f7_s7.vld;
		f8_d.mode  = f7_s7.mode;
		f8_d.tex_u = f7_s7.tex_u;
		f8_d.tex_v = f7_s7.tex_v;
		f8_d.n0    = f7_s7.n0;
		f8_d.n1    = f7_s7.n1;
		f8_d.n2    = f7_s7.n2;
		f8_d.tg0   = f7_s7.tg0;
		f8_d.tg2   = f7_s7.tg2;
		f8_d.ba    = 64'(f7_s7.n1) * 64'(f7_s7.tg2);
		f8_d.bb    = 64'(f7_s7.n2) * 64'(f7_s7.tg0);
		f8_d.bc    = 64'(f7_s7.n0) * 64'(f7_s7.tg2);
		f8_d.bd    = 64'(f7_s7.n1) * 64'(f7_s7.tg0);
		f8_d.pos0  = 64'(rs) * 64'(f7_s7.n0);
		f8_d.pos1  = 64'(rs) * 64'(f7_s7.n1);
		f8_d.pos2  = 64'(rs) * 64'(f7_s7.n2);
	end

	// Output selection, rounding to Q16.16 and saturation
	always_comb begin
		res_d     = '0;
		res_d.vld = f8_s8.vld;
		res_d.cnt = 2'd3;
		case (f8_s8.mode)
			MODE_POS2D, MODE_POS3D: begin
				res_d.x = sat32(round_shift(f8_s8.pos0, 38 - FRAC_BITS));
				res_d.y = sat32(round_shift(f8_s8.pos1, 38 - FRAC_BITS));
				if (f8_s8.mode == MODE_POS2D) begin
					res_d.cnt = 2'd2;
				end else begin
					res_d.z = sat32(round_shift(f8_s8.pos2, 38 - FRAC_BITS));
				end
			end
			MODE_TEX: begin
				res_d.x   = COMP_W'(f8_s8.tex_u);
				res_d.y   = COMP_W'(f8_s8.tex_v);
				res_d.cnt = 2'd2;
			end
			MODE_NORMAL: begin
				res_d.x = sat32(round_shift(64'(f8_s8.n0), 30 - FRAC_BITS));
				res_d.y = sat32(round_shift(64'(f8_s8.n1), 30 - FRAC_BITS));
				res_d.z = sat32(round_shift(64'(f8_s8.n2), 30 - FRAC_BITS));
			end
			MODE_TANGENT: begin
				res_d.x = sat32(round_shift(64'(f8_s8.tg0), 30 - FRAC_BITS));
				res_d.z = sat32(round_shift(64'(f8_s8.tg2), 30 - FRAC_BITS));
			end
			MODE_BITAN: begin
				res_d.x = sat32(round_shift(f8_s8.ba, 60 - FRAC_BITS));
				res_d.y = sat32(round_shift(f8_s8.bb - f8_s8.bc, 60 - FRAC_BITS));
				res_d.z = sat32(round_shift(-f8_s8.bd, 60 - FRAC_BITS));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f5_s5  <= '0;
			f6_s6  <= '0;
			f7_s7  <= '0;
			f8_s8  <= '0;
			res_s9 <= '0;
		end else if (adv) begin
			f5_s5  <= f5_d;
			f6_s6  <= f6_d;
			f7_s7  <= f7_d;
			f8_s8  <= f8_d;
			res_s9 <= res_d;
		end
	end

	assign vtx_out.valid      = res_s9.vld;
	assign vtx_out.comp_x     = res_s9.x;
	assign vtx_out.comp_y     = res_s9.y;
	assign vtx_out.comp_z     = res_s9.z;
	assign vtx_out.comp_count = res_s9.cnt;

endmodule

### design/uvs_checker.sv
// Port-level assertions for the UV-sphere vertex attribute block, bound to the top.
module uvs_checker import uvs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [COMP_W-1:0] comp_x,
	input logic [COMP_W-1:0] comp_y,
	input logic [COMP_W-1:0] comp_z,
	input logic [1:0]        comp_count
);

	// Result beat stays up until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// Stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(comp_x) && $stable(comp_y) &&
			$stable(comp_z) && $stable(comp_count))
		else $error("output payload changed while stalled");

	// Input ready is high exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// Component count is two or three
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> comp_count == 2'd2 || comp_count == 2'd3)
		else $error("bad component count");

	// Two-component results leave z at zero
	a_zero_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && comp_count == 2'd2 |-> comp_z == '0)
		else $error("z not zero on two-component result");

endmodule

bind uv_sphere_vertex_attributes_top uvs_checker u_uvs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (vtx_in.ready),
	.out_valid  (vtx_out.valid),
	.out_ready  (vtx_out.ready),
	.comp_x     (vtx_out.comp_x),
	.comp_y     (vtx_out.comp_y),
	.comp_z     (vtx_out.comp_z),
	.comp_count (vtx_out.comp_count)
);

### dv/uvs_checker.sv
// Checker for the UV-sphere vertex block: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module uvs_scoreboard import uvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [RAD_W-1:0] cfg_wdata,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [CNT_W-1:0] in_ring,
	input  logic [CNT_W-1:0] in_seg,
	input  logic [MODE_W-1:0] in_mode,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [COMP_W-1:0] out_x,
	input  logic [COMP_W-1:0] out_y,
	input  logic [COMP_W-1:0] out_z,
	input  logic [1:0]       out_count,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  cnt;
	} attr_t;

	attr_t attr_q[$];
	logic [CNT_W-1:0] ring_cfg, seg_cfg;
	logic [RAD_W-1:0] rad_cfg;

	assign pending = attr_q.size();

	function automatic longint unsigned taylor_step(longint unsigned x2, longint unsigned t,
			longint unsigned d);
		longint unsigned p;
		p = ((x2 * t) >> 30) / d;
		return (p >= 64'd1 << 30) ? 0 : (64'd1 << 30) - p;
	endfunction

	// sin/cos of a 32-bit turn fraction, Q30
	task automatic turn_trig(input logic [31:0] a, output longint sn, output longint cs);
		longint unsigned r, x, x2, t;
		longint s0, c0;
		r = a[29:0];
		x = (r * 64'd1686629713 + (64'd1 << 29)) >> 30;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		t = 64'd1 << 30;
		t = taylor_step(x2, t, 110); t = taylor_step(x2, t, 72);
		t = taylor_step(x2, t, 42); t = taylor_step(x2, t, 20);
		t = taylor_step(x2, t, 6);
		s0 = longint'((x * t) >> 30);
		t = 64'd1 << 30;
		t = taylor_step(x2, t, 132); t = taylor_step(x2, t, 90);
		t = taylor_step(x2, t, 56); t = taylor_step(x2, t, 30);
		t = taylor_step(x2, t, 12); t = taylor_step(x2, t, 2);
		c0 = longint'(t);
		case (a[31:30])
			2'd0: begin sn = s0; cs = c0; end
			2'd1: begin sn = c0; cs = -s0; end
			2'd2: begin sn = -s0; cs = -c0; end
			default: begin sn = -c0; cs = s0; end
		endcase
	endtask

	function automatic longint rnd_shr(longint v, int k);
		longint h;
		h = longint'(1) << (k - 1);
		return (v >= 0) ? (v + h) >>> k : -((-v + h) >>> k);
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic longint unsigned div_count(logic [CNT_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIVISIONS) return MAX_DIVISIONS;
		return v;
	endfunction

	// Expected attribute for one request under the current register values
	task automatic vertex_attr(input logic [CNT_W-1:0] ri, input logic [CNT_W-1:0] si,
			input logic [MODE_W-1:0] md, output attr_t res);
		longint unsigned ring, seg, nr, ns;
		longint rad, st, ct, sp, cp, ast;
		longint n[3], tg[3], b[3], r[3];
		logic [31:0] ta, pa;
		nr = div_count(ring_cfg);
		ns = div_count(seg_cfg);
		ring = (ri > nr) ? nr : ri;
		seg = (si > ns) ? ns : si;
		rad = (rad_cfg == 0) ? 1 : rad_cfg;
		ta = 32'(((ring << 31) + nr / 2) / nr);
		pa = 32'(((seg << 32) + ns / 2) / ns);
		turn_trig(ta, st, ct);
		turn_trig(pa, sp, cp);
		n[0] = rnd_shr(st * cp, 30);
		n[1] = ct;
		n[2] = rnd_shr(st * sp, 30);
		ast = st < 0 ? -st : st;
		// near a pole the tangent falls back to +/- z
		if (rad * ast < 274878) begin
			tg[0] = 0; tg[1] = 0; tg[2] = ct >= 0 ? (64'sd1 << 30) : -(64'sd1 << 30);
		end else begin
			tg[0] = -sp; tg[1] = 0; tg[2] = cp;
		end
		b[0] = n[1] * tg[2] - n[2] * tg[1];
		b[1] = n[2] * tg[0] - n[0] * tg[2];
		b[2] = n[0] * tg[1] - n[1] * tg[0];
		r = '{0, 0, 0};
		res.cnt = 2'd3;
		case (md)
			MODE_POS2D, MODE_POS3D: begin
				for (int i = 0; i < 3; i++) r[i] = rnd_shr(rad * n[i], 38 - FRAC_BITS);
				if (md == MODE_POS2D) begin r[2] = 0; res.cnt = 2'd2; end
			end
			MODE_TEX: begin
				r[0] = longint'(((seg << FRAC_BITS) + ns / 2) / ns);
				r[1] = longint'(((ring << FRAC_BITS) + nr / 2) / nr);
				res.cnt = 2'd2;
			end
			MODE_NORMAL: for (int i = 0; i < 3; i++) r[i] = rnd_shr(n[i], 30 - FRAC_BITS);
			MODE_TANGENT: for (int i = 0; i < 3; i++) r[i] = rnd_shr(tg[i], 30 - FRAC_BITS);
			MODE_BITAN: for (int i = 0; i < 3; i++) r[i] = rnd_shr(b[i], 60 - FRAC_BITS);
			default: ;
		endcase
		res.x = clip32(r[0]);
		res.y = clip32(r[1]);
		res.z = clip32(r[2]);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	// Register shadow, request prediction, result compare
	always @(posedge clk or negedge arst_n) begin
		attr_t e;
		if (!arst_n) begin
			ring_cfg <= RING_COUNT_RST;
			seg_cfg <= SEG_COUNT_RST;
			rad_cfg <= RADIUS_RST;
			attr_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				vertex_attr(in_ring, in_seg, in_mode, e);
				attr_q.insert(attr_q.size(), e);
			end
			if (out_valid && out_ready) begin
				if (attr_q.size() == 0) begin
					report("unexpected beat", out_x, 0);
				end else begin
					e = attr_q.pop_front();
					if (out_x !== e.x) report("comp_x", out_x, e.x);
					if (out_y !== e.y) report("comp_y", out_y, e.y);
					if (out_z !== e.z) report("comp_z", out_z, e.z);
					if (out_count !== e.cnt) report("comp_count", out_count, e.cnt);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RING_COUNT: ring_cfg <= cfg_wdata[CNT_W-1:0];
					REG_SEG_COUNT: seg_cfg <= cfg_wdata[CNT_W-1:0];
					REG_RADIUS: rad_cfg <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

### dv/tb.sv
// Testbench top: stimulus, configuration phases, stalls and the verdict.
`timescale 1ns / 100ps
module tb;
	import uvs_pkg::*;

	localparam int LATENCY = 59;
	localparam int STALL_LIMIT = 20000;

	logic clk, arst_n, cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [RAD_W-1:0] cfg_wdata;
	int fail_count, pending, idle_cycles;
	int rx_wait;
	logic rx_hold;
	logic rx_random;
	logic [CNT_W-1:0] cur_ring, cur_seg;

	uvs_in_if vtx_in();
	uvs_out_if vtx_out();

	uv_sphere_vertex_attributes_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .vtx_in(vtx_in), .vtx_out(vtx_out));

	uvs_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(vtx_in.valid), .in_ready(vtx_in.ready),
		.in_ring(vtx_in.ring_index), .in_seg(vtx_in.segment_index), .in_mode(vtx_in.mode),
		.out_valid(vtx_out.valid), .out_ready(vtx_out.ready), .out_x(vtx_out.comp_x),
		.out_y(vtx_out.comp_y), .out_z(vtx_out.comp_z), .out_count(vtx_out.comp_count),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Send one request beat after a random gap; valid stays up for a following beat
	task automatic send_vertex(input logic [CNT_W-1:0] ri, input logic [CNT_W-1:0] si,
			input logic [MODE_W-1:0] md, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
		if (gap > 0) begin
			vtx_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_in.valid <= 1'b1;
		vtx_in.ring_index <= ri;
		vtx_in.segment_index <= si;
		vtx_in.mode <= md;
		do @(posedge clk); while (!vtx_in.ready);
	endtask

	// Caller drops cfg_we after the last write
	task automatic write_reg(input uvs_reg_t idx, input logic [RAD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic drain;
		vtx_in.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Random request; mostly in range, sometimes over the count or anywhere
	task automatic random_vertex(input bit no_gap);
		logic [CNT_W-1:0] ri, si;
		int sel;
		sel = $urandom_range(0, 9);
		ri = (sel == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, cur_ring));
		si = (sel == 1) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, cur_seg));
		send_vertex(ri, si, MODE_W'($urandom_range(0, 7)), no_gap);
	endtask

	// Receiver: always ready, random wait after each beat, or a long hold
	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			vtx_out.ready <= 1'b0;
			rx_wait <= 0;
		end else if (rx_hold) begin
			vtx_out.ready <= 1'b0;
		end else if (!rx_random) begin
			vtx_out.ready <= 1'b1;
		end else if (vtx_out.valid && vtx_out.ready) begin
			w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
			rx_wait <= w;
			vtx_out.ready <= (w == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			vtx_out.ready <= (rx_wait == 1);
		end else begin
			vtx_out.ready <= 1'b1;
		end
	end

	// Watchdog on accepted beats
	always @(posedge clk) begin
		if ((vtx_in.valid && vtx_in.ready) || (vtx_out.valid && vtx_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0] rings[6] = '{1, 2, 3, 16, 1024, 0};
		logic [CNT_W-1:0] segs[6] = '{1, 3, 4, 32, 1024, 2047};
		logic [RAD_W-1:0] rads[6] = '{1, 255, 256, 65535, 0, 1000};
		idle_cycles = 0;
		rx_hold = 0;
		rx_random = 0;
		cfg_we = 0; cfg_index = REG_RING_COUNT; cfg_wdata = 0;
		vtx_in.valid = 0; vtx_in.ring_index = 0; vtx_in.segment_index = 0; vtx_in.mode = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset registers, poles, seams, every mode, out-of-range
		cur_ring = 16; cur_seg = 32;
		for (int m = 0; m < 8; m++) send_vertex(0, 0, MODE_W'(m), 1);
		for (int m = 0; m < 8; m++) send_vertex(16, 32, MODE_W'(m), 1);
		send_vertex(8, 8, MODE_BITAN, 1);
		send_vertex(2047, 2047, MODE_POS3D, 1);
		send_vertex(1024, 5, MODE_TANGENT, 1);
		send_vertex(3, 1024, MODE_TEX, 1);
		send_vertex(5, 7, MODE_NORMAL, 1);
		drain();

		rx_random = 1;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_RING_COUNT, rings[ph]);
			write_reg(REG_SEG_COUNT, segs[ph]);
			write_reg(REG_RADIUS, rads[ph]);
			cfg_we <= 1'b0;
			cur_ring = (rings[ph] == 0) ? 1 : rings[ph];
			cur_seg = (segs[ph] > 1024) ? 1024 : segs[ph];
			if (ph == 2) begin
				// Long receiver hold while requests keep coming
				fork
					begin
						rx_hold = 1;
						repeat (300) @(posedge clk);
						rx_hold = 0;
					end
					for (int i = 0; i < 80; i++) random_vertex(1);
				join
			end
			for (int i = 0; i < 125; i++) begin
				random_vertex(0);
				// sender pause until everything is back
				if (i == 60) begin
					vtx_in.valid <= 1'b0;
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### uv_sphere_vertex_attributes_top.f
design/uvs_pkg.sv
design/uvs_if.sv
design/uvs_div_cell.sv
design/uvs_horner_cell.sv
design/uv_sphere_vertex_attributes_top.sv
design/uvs_checker.sv
dv/uvs_checker.sv
dv/tb.sv
